// ----- hw/rtl/rasst_pkg.sv -----
package rasst_pkg;

  localparam int unsigned SumW           = 26;
  localparam int unsigned TagW           = 16;
  localparam int unsigned FieldW         = 11;
  localparam int unsigned CfgW           = 11;
  localparam int unsigned MaxElementsDef = 1024;
  localparam logic [CfgW-1:0] ActiveSizeRst = CfgW'(1024);

  typedef struct packed {
    logic            pend;
    logic [TagW-1:0] tag;
    logic [SumW-1:0] sum;
  } node_word_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_COVER,
    WR_UNTAG,
    WR_PUSH_L,
    WR_PUSH_R,
    WR_COMB
  } wr_sel_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOP,
    RD_LC,
    RD_RC
  } rd_sel_e;

  typedef enum logic [2:0] {
    STK_NONE,
    STK_ROOT,
    STK_DESC,
    STK_RIGHT,
    STK_POP
  } stk_op_e;

  typedef struct packed {
    logic    clr_start;
    logic    req_load;
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    stk_op_e stk_op;
    logic    acc_add;
    logic    lsum_load;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic req_ok;
    logic req_assign;
    logic full_cover;
    logic tag_valid;
    logic stk_empty;
    logic top_left;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/rasst_dp.sv -----
module rasst_dp import rasst_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              mode_i,
  input  logic [FieldW-1:0] range_low_i,
  input  logic [FieldW-1:0] range_high_i,
  input  logic [TagW-1:0]   value_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [SumW-1:0]   range_sum_o,
  output logic              range_error_o
);

  localparam int unsigned IdxW  = $clog2(MaxElements + 1);
  localparam int unsigned RW    = (IdxW > FieldW) ? IdxW : FieldW;
  localparam int unsigned NodeN = 2 * MaxElements;
  localparam int unsigned NodeW = $clog2(NodeN);
  localparam int unsigned StkD  = $clog2(MaxElements) + 1;
  localparam int unsigned StkIw = (StkD > 1) ? $clog2(StkD) : 1;
  localparam int unsigned StkN  = 1 << StkIw;
  localparam int unsigned SpW   = $clog2(StkN + 1);
  localparam int unsigned PW    = RW + TagW;

  // node memory
  node_word_t mem_q [NodeN];
  node_word_t rdata_q;
  logic       we;
  logic [NodeW-1:0] wa, ra;
  node_word_t wd;
  logic       re;

  // request
  logic            req_mode_q;
  logic [RW-1:0]   req_a_q, req_b_q;
  logic [TagW-1:0] req_v_q;
  logic            req_ok_q;
  logic [CfgW-1:0] active_size_q;
  logic [RW-1:0]   as_ext, eff_size, a_in, b_in;
  logic            ok_in;

  logic [SumW-1:0]  acc_q, lsum_q;
  logic [NodeW-1:0] clr_q;

  // frame stack
  logic [NodeW-1:0] stk_id   [StkN];
  logic [RW-1:0]    stk_lo   [StkN];
  logic [RW-1:0]    stk_hi   [StkN];
  logic [RW-1:0]    stk_a    [StkN];
  logic [RW-1:0]    stk_b    [StkN];
  logic             stk_left [StkN];
  logic [SpW-1:0]   sp_q;
  logic [SpW-1:0]   sp_dec;
  logic [StkIw-1:0] ti, si;

  logic [NodeW-1:0] t_id, lc, rc;
  logic [RW-1:0]    t_lo, t_hi, t_a, t_b, mid, len_t, len_l, len_r;
  logic [RW:0]      lohi_sum;
  logic             t_left, go_l, go_r;

  logic [RW-1:0]   mul_len;
  logic [TagW-1:0] mul_val;
  logic [PW-1:0]   prod;

  logic              out_valid_q, out_err_q, out_free;
  logic [SumW-1:0]   out_sum_q;

  assign sp_dec = sp_q - SpW'(1);
  assign ti     = sp_dec[StkIw-1:0];
  assign si     = sp_q[StkIw-1:0];

  assign t_id   = stk_id[ti];
  assign t_lo   = stk_lo[ti];
  assign t_hi   = stk_hi[ti];
  assign t_a    = stk_a[ti];
  assign t_b    = stk_b[ti];
  assign t_left = stk_left[ti];

  assign lohi_sum = {1'b0, t_lo} + {1'b0, t_hi};
  assign mid      = lohi_sum[RW:1];
  assign len_t    = t_hi - t_lo + RW'(1);
  assign len_l    = mid - t_lo + RW'(1);
  assign len_r    = t_hi - mid;
  assign lc       = t_id + NodeW'(1);
  assign rc       = t_id + NodeW'({len_l, 1'b0});
  assign go_l     = (t_b <= mid);
  assign go_r     = (t_a > mid);

  // effective size and range check
  assign as_ext   = RW'(active_size_q);
  assign eff_size = (as_ext == '0) ? RW'(1) :
                    (as_ext > RW'(MaxElements)) ? RW'(MaxElements) : as_ext;
  assign a_in     = RW'(range_low_i);
  assign b_in     = RW'(range_high_i);
  assign ok_in    = (a_in != '0) && (a_in <= b_in) && (b_in <= eff_size);

  // shared cover multiplier
  always_comb begin
    mul_len = len_t;
    mul_val = req_v_q;
    unique case (cmd_i.wr_sel)
      WR_PUSH_L: begin
        mul_len = len_l;
        mul_val = rdata_q.tag;
      end
      WR_PUSH_R: begin
        mul_len = len_r;
        mul_val = rdata_q.tag;
      end
      default: begin
        mul_len = len_t;
        mul_val = req_v_q;
      end
    endcase
  end

  assign prod = PW'(mul_len) * PW'(mul_val);

  always_comb begin
    we = 1'b1;
    wa = t_id;
    wd = '0;
    unique case (cmd_i.wr_sel)
      WR_NONE:  we = 1'b0;
      WR_CLEAR: wa = clr_q;
      WR_COVER: wd = '{pend: 1'b1, tag: req_v_q, sum: prod[SumW-1:0]};
      WR_UNTAG: wd = '{pend: 1'b0, tag: '0, sum: rdata_q.sum};
      WR_PUSH_L: begin
        wa = lc;
        wd = '{pend: 1'b1, tag: rdata_q.tag, sum: prod[SumW-1:0]};
      end
      WR_PUSH_R: begin
        wa = rc;
        wd = '{pend: 1'b1, tag: rdata_q.tag, sum: prod[SumW-1:0]};
      end
      WR_COMB:  wd = '{pend: 1'b0, tag: '0, sum: lsum_q + rdata_q.sum};
      default:  we = 1'b0;
    endcase
  end

  always_comb begin
    re = 1'b1;
    ra = t_id;
    unique case (cmd_i.rd_sel)
      RD_NONE: re = 1'b0;
      RD_TOP:  ra = t_id;
      RD_LC:   ra = lc;
      RD_RC:   ra = rc;
      default: re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem_q[ra];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= ActiveSizeRst;
      clr_q         <= '0;
      sp_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_size_q <= cfg_data_i;
      end
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.wr_sel == WR_CLEAR) begin
        clr_q <= clr_q + NodeW'(1);
      end
      unique case (cmd_i.stk_op)
        STK_ROOT:  sp_q <= SpW'(1);
        STK_DESC:  sp_q <= sp_q + SpW'(1);
        STK_RIGHT: sp_q <= sp_q + SpW'(1);
        STK_POP:   sp_q <= sp_dec;
        default:   sp_q <= sp_q;
      endcase
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_mode_q <= mode_i;
      req_a_q    <= a_in;
      req_b_q    <= b_in;
      req_v_q    <= value_i;
      req_ok_q   <= ok_in;
      acc_q      <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + rdata_q.sum;
    end
    if (cmd_i.lsum_load) begin
      lsum_q <= rdata_q.sum;
    end
    if (cmd_i.out_load) begin
      out_sum_q <= acc_q;
      out_err_q <= !req_ok_q;
    end
    unique case (cmd_i.stk_op)
      STK_ROOT: begin
        stk_id[0]   <= '0;
        stk_lo[0]   <= RW'(1);
        stk_hi[0]   <= eff_size;
        stk_a[0]    <= req_a_q;
        stk_b[0]    <= req_b_q;
        stk_left[0] <= 1'b0;
      end
      STK_DESC: begin
        stk_left[ti] <= !(go_l || go_r);
        stk_id[si]   <= go_r ? rc : lc;
        stk_lo[si]   <= go_r ? (mid + RW'(1)) : t_lo;
        stk_hi[si]   <= go_r ? t_hi : mid;
        stk_a[si]    <= t_a;
        stk_b[si]    <= (go_l || go_r) ? t_b : mid;
        stk_left[si] <= 1'b0;
      end
      STK_RIGHT: begin
        stk_left[ti] <= 1'b0;
        stk_id[si]   <= rc;
        stk_lo[si]   <= mid + RW'(1);
        stk_hi[si]   <= t_hi;
        stk_a[si]    <= mid + RW'(1);
        stk_b[si]    <= t_b;
        stk_left[si] <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o = '{
    req_ok:     req_ok_q,
    req_assign: req_mode_q,
    full_cover: (t_lo == t_a) && (t_hi == t_b),
    tag_valid:  rdata_q.pend,
    stk_empty:  (sp_q == '0),
    top_left:   t_left,
    clr_last:   (clr_q == NodeW'(NodeN - 1)),
    out_free:   out_free
  };

  assign out_valid_o   = out_valid_q;
  assign range_sum_o   = out_sum_q;
  assign range_error_o = out_err_q;

endmodule

// ----- hw/rtl/rasst_ctrl.sv -----
module rasst_ctrl import rasst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'h001,
    ST_CLEAR  = 12'h002,
    ST_START  = 12'h004,
    ST_RD     = 12'h008,
    ST_EVAL   = 12'h010,
    ST_PUSH_L = 12'h020,
    ST_PUSH_R = 12'h040,
    ST_DESC   = 12'h080,
    ST_RET    = 12'h100,
    ST_CMB1   = 12'h200,
    ST_CMB2   = 12'h400,
    ST_FIN    = 12'h800
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ST_START;
        end
      end
      ST_CLEAR: begin
        cmd_o.wr_sel = WR_CLEAR;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_START: begin
        if (!sts_i.req_ok) begin
          state_d = sts_i.req_assign ? ST_IDLE : ST_FIN;
        end else begin
          cmd_o.stk_op = STK_ROOT;
          state_d      = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_sel = RD_TOP;
        state_d      = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.full_cover) begin
          if (sts_i.req_assign) begin
            cmd_o.wr_sel = WR_COVER;
          end else begin
            cmd_o.acc_add = 1'b1;
          end
          cmd_o.stk_op = STK_POP;
          state_d      = ST_RET;
        end else if (sts_i.tag_valid) begin
          // drop the tag here, hand it to both children next
          cmd_o.wr_sel = WR_UNTAG;
          state_d      = ST_PUSH_L;
        end else begin
          state_d = ST_DESC;
        end
      end
      ST_PUSH_L: begin
        cmd_o.wr_sel = WR_PUSH_L;
        state_d      = ST_PUSH_R;
      end
      ST_PUSH_R: begin
        cmd_o.wr_sel = WR_PUSH_R;
        state_d      = ST_DESC;
      end
      ST_DESC: begin
        cmd_o.stk_op = STK_DESC;
        state_d      = ST_RD;
      end
      ST_RET: begin
        if (sts_i.stk_empty) begin
          state_d = sts_i.req_assign ? ST_IDLE : ST_FIN;
        end else if (sts_i.top_left) begin
          cmd_o.stk_op = STK_RIGHT;
          state_d      = ST_RD;
        end else if (sts_i.req_assign) begin
          // rebuild the parent sum from both children
          cmd_o.rd_sel = RD_LC;
          state_d      = ST_CMB1;
        end else begin
          cmd_o.stk_op = STK_POP;
          state_d      = ST_RET;
        end
      end
      ST_CMB1: begin
        cmd_o.lsum_load = 1'b1;
        cmd_o.rd_sel    = RD_RC;
        state_d         = ST_CMB2;
      end
      ST_CMB2: begin
        cmd_o.wr_sel = WR_COMB;
        cmd_o.stk_op = STK_POP;
        state_d      = ST_RET;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a size change reshapes the tree: restart the clearing sweep
    if (cfg_we_i) begin
      cmd_o.clr_start = 1'b1;
      cmd_o.wr_sel    = WR_NONE;
      state_d         = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- hw/rtl/range_assign_range_sum_tree_unit.sv -----
// Per visited node: step down, read, evaluate; where a cover tag is pushed to the children,
// it is dropped and then written to the left and then the right child; on assign, the return
// through a node after both children rebuilds its sum (read left, read right, write parent).
// Throughput: one word at a time; the next word is taken once the current one finishes.
// Reset, and every write of active_size, runs a clearing sweep over all 2*MaxElements words
// of node memory; no word is taken until it ends.
module range_assign_range_sum_tree_unit import rasst_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgW-1:0]   cfg_active_size_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [FieldW-1:0] range_low_i,
  input  logic [FieldW-1:0] range_high_i,
  input  logic [TagW-1:0]   value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SumW-1:0]   range_sum_o,
  output logic              range_error_o
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  rasst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  rasst_dp #(
    .MaxElements (MaxElements)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_active_size_i),
    .mode_i        (mode_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .range_sum_o   (range_sum_o),
    .range_error_o (range_error_o)
  );

  a_err_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (range_sum_o == '0))
    else $error("error result carries a nonzero sum");

  a_accept_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> sts.stk_empty)
    else $error("word accepted with frames left on the stack");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> in_stall_o)
    else $error("size write did not start the clearing sweep");

endmodule

// ----- test/range_assign_range_sum_tree_unit_check.sv -----
`timescale 1ns / 100ps

module range_assign_range_sum_tree_unit_check import rasst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CfgW-1:0]   cfg_active_size_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              mode_i,
  input  logic [FieldW-1:0] range_low_i,
  input  logic [FieldW-1:0] range_high_i,
  input  logic [TagW-1:0]   value_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [SumW-1:0]   range_sum_i,
  input  logic              range_error_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            err;
  } sum_result_t;

  logic [TagW-1:0] elem_q [1:MaxElementsDef];
  int unsigned     tree_size;
  sum_result_t     sum_expect_q [$];

  // Element row model: lazy tags do not change the visible values.
  function automatic sum_result_t sum_of_range(int unsigned lo, int unsigned hi);
    sum_result_t r;
    longint      acc;
    acc = 0;
    for (int unsigned i = lo; i <= hi; i++) acc += elem_q[i];
    r.sum = acc[SumW-1:0];
    r.err = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sum_result_t got, want;
    int unsigned lo, hi;
    logic        ok;
    if (!rst_ni) begin
      tree_size = MaxElementsDef;
      for (int i = 1; i <= MaxElementsDef; i++) elem_q[i] = '0;
      sum_expect_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // drain first: a result leaving now belongs to an older word
      if (out_valid_i && !out_stall_i) begin
        got.sum = range_sum_i;
        got.err = range_error_i;
        if (sum_expect_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result sum=%0d err=%0b", got.sum, got.err);
        end else begin
          want = sum_expect_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected sum=%0d err=%0b, got sum=%0d err=%0b",
                       want.sum, want.err, got.sum, got.err);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        lo = range_low_i;
        hi = range_high_i;
        ok = (lo >= 1) && (lo <= hi) && (hi <= tree_size);
        if (mode_i) begin
          if (ok) for (int unsigned i = lo; i <= hi; i++) elem_q[i] = value_i;
        end else if (ok) begin
          sum_expect_q.push_back(sum_of_range(lo, hi));
        end else begin
          want.sum = '0;
          want.err = 1'b1;
          sum_expect_q.push_back(want);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        tree_size = cfg_active_size_i;
        if (tree_size < 1) tree_size = 1;
        if (tree_size > MaxElementsDef) tree_size = MaxElementsDef;
        for (int i = 1; i <= MaxElementsDef; i++) elem_q[i] = '0;
      end
      pending_o = sum_expect_q.size();
    end
  end

endmodule

// ----- test/range_assign_range_sum_tree_unit_test.sv -----
`timescale 1ns / 100ps

module range_assign_range_sum_tree_unit_test import rasst_pkg::*;;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CfgW-1:0]   cfg_active_size;
  logic              in_valid;
  logic              in_stall;
  logic              mode;
  logic [FieldW-1:0] range_low;
  logic [FieldW-1:0] range_high;
  logic [TagW-1:0]   value;
  logic              out_valid;
  logic              out_stall;
  logic [SumW-1:0]   range_sum;
  logic              range_error;
  int                fail_count;
  int                pending;

  int          send_idle_pct;
  int          stall_pct;
  logic        hold_req;
  int unsigned cur_size;

  range_assign_range_sum_tree_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_active_size_i(cfg_active_size),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (mode),
    .range_low_i      (range_low),
    .range_high_i     (range_high),
    .value_i          (value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .range_sum_o      (range_sum),
    .range_error_o    (range_error)
  );

  range_assign_range_sum_tree_unit_check check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_active_size_i(cfg_active_size),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .mode_i           (mode),
    .range_low_i      (range_low),
    .range_high_i     (range_high),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .range_sum_i      (range_sum),
    .range_error_i    (range_error),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall, plus a long hold whenever hold_req toggles
  initial begin
    logic hold_seen;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        for (int n = 0; n < 1500; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #50_000_000;
    $display("range_assign_range_sum_tree_unit test failed");
    $finish;
  end

  // wait for every result and for the block to finish its current word
  task automatic wait_idle();
    while (pending != 0 || in_stall) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_size(input int unsigned sz);
    wait_idle();
    cfg_valid       <= 1'b1;
    cfg_active_size <= sz[CfgW-1:0];
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    cur_size = (sz < 1) ? 1 : (sz > MaxElementsDef) ? MaxElementsDef : sz;
  endtask

  task automatic send_word(input logic m, input int unsigned lo, input int unsigned hi,
                           input int unsigned v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    range_low  <= lo[FieldW-1:0];
    range_high <= hi[FieldW-1:0];
    value      <= v[TagW-1:0];
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic send_random();
    int unsigned lo, hi, v, pick;
    pick = $urandom_range(9);
    v = (pick == 0) ? 0 : (pick == 1) ? 16'hffff : $urandom_range(16'hffff);
    if ($urandom_range(99) < 85) begin
      lo = $urandom_range(cur_size, 1);
      hi = $urandom_range(cur_size, lo);
    end else begin
      lo = $urandom_range(2047);
      hi = $urandom_range(2047);
    end
    send_word(1'($urandom_range(1)), lo, hi, v);
  endtask

  task automatic run_phase(input int idle_p, input int stall_p, input int count);
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    for (int i = 0; i < count; i++) send_random();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_active_size = '0;
    in_valid = 1'b0;
    mode = 1'b0;
    range_low = '0;
    range_high = '0;
    value = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    cur_size = MaxElementsDef;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full span, single ends, bad ranges
    send_word(1'b0, 1, 1024, 0);
    send_word(1'b1, 1, 1024, 16'hffff);
    send_word(1'b0, 1, 1024, 0);
    send_word(1'b1, 1, 1, 0);
    send_word(1'b0, 1, 1, 0);
    send_word(1'b0, 1024, 1024, 0);
    send_word(1'b1, 512, 513, 1234);
    send_word(1'b0, 511, 514, 0);
    send_word(1'b0, 0, 5, 0);
    send_word(1'b0, 9, 8, 0);
    send_word(1'b0, 1, 1025, 0);
    send_word(1'b0, 2047, 2047, 0);
    send_word(1'b1, 0, 10, 777);
    send_word(1'b1, 20, 10, 777);
    send_word(1'b1, 1000, 1025, 777);
    send_word(1'b0, 1, 1024, 0);
    send_word(1'b1, 3, 900, 16'h5a5a);
    send_word(1'b0, 2, 901, 0);
    send_word(1'b1, 1024, 1024, 16'h8001);
    send_word(1'b0, 1000, 1024, 0);
    send_word(1'b0, 1, 1024, 0);
    in_valid <= 1'b0;
    @(posedge clk);

    run_phase(0, 0, 150);
    write_size(1);
    run_phase(84, 0, 60);
    write_size(0);
    run_phase(0, 84, 40);
    write_size(7);
    run_phase(36, 36, 120);
    write_size(2047);
    run_phase(84, 0, 150);
    write_size(100);
    // back up the output so the block stalls its input
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    for (int i = 0; i < 30; i++) send_word(1'b0, 1, 100, 0);
    run_phase(0, 84, 150);
    write_size(1024);
    run_phase(36, 36, 150);
    run_phase(0, 0, 180);

    stall_pct = 0;
    wait_idle();
    if (fail_count == 0) begin
      $display("range_assign_range_sum_tree_unit test passed");
    end else begin
      $display("range_assign_range_sum_tree_unit test failed");
    end
    $finish;
  end

endmodule
